[hw/rtl/cwc_pkg.sv]
// Shared types, constants and helpers for the cylinder wall collision core.
// Used by the sqrt and divider cells and the top level.
package cwc_pkg;

    // Fixed-point format of all positions and velocities
    localparam int FRAC_BITS = 16;
    // Signed width of a unit normal component (magnitude up to 1.0)
    localparam int NW = FRAC_BITS + 2;
    // Cells in the square-root chain (one root bit each)
    localparam int SQRT_CELLS = 32;
    // Cells in the divider chain (one quotient bit each)
    localparam int DIV_CELLS = 32;
    // Divider lanes: wall x, wall z, normal x, normal z
    localparam int LANES = 4;
    localparam int LN_WX = 0;
    localparam int LN_WZ = 1;
    localparam int LN_NX = 2;
    localparam int LN_NZ = 3;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_AXIS_X  = 3'd0,
        CFG_AXIS_Z  = 3'd1,
        CFG_FLOOR_Y = 3'd2,
        CFG_RADIUS  = 3'd3,
        CFG_WVC_X   = 3'd4,
        CFG_WVC_Y   = 3'd5,
        CFG_WVC_Z   = 3'd6
    } cfg_idx_t;

    // Square-root cell data: remaining radicand bits, partial remainder, root
    typedef struct packed {
        logic [63:0] x;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_t;

    // One divider lane: partial remainder, remaining numerator bits, quotient
    typedef struct packed {
        logic [31:0] r;
        logic [31:0] low;
        logic [31:0] q;
    } div_lane_t;

    typedef struct packed {
        logic [31:0]                 d;
        div_lane_t [LANES-1:0]       lane;
    } div_t;

    // Particle data carried beside the sqrt and divider chains
    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        fhit;
        logic        whit;
        logic        sgnx;
        logic        sgnz;
        logic [31:0] ax;
        logic [31:0] az;
        logic [63:0] numx;
        logic [63:0] numz;
    } pay_t;

    // Clamp to the 32-bit signed range
    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -40'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[hw/rtl/cwc_sqrt_cell.sv]
// One step of the digit-by-digit integer square root: one root bit per cell.
// Depends on cwc_pkg for the cell data type.
module cwc_sqrt_cell (
    input  logic            clk,
    input  logic            en,
    input  cwc_pkg::sqrt_t  c_in,
    output cwc_pkg::sqrt_t  c_out
);

    logic [35:0]    rem2;
    logic [35:0]    trial;
    logic [35:0]    diff;
    logic           ge;
    cwc_pkg::sqrt_t c_next;

    // Bring down two radicand bits and try the next root bit
    always_comb
    begin
        rem2         = {c_in.rem, c_in.x[63:62]};
        trial        = {2'b00, c_in.root, 2'b01};
        diff         = rem2 - trial;
        ge           = (rem2 >= trial);
        c_next.x     = {c_in.x[61:0], 2'b00};
        c_next.rem   = ge ? diff[33:0] : rem2[33:0];
        c_next.root  = {c_in.root[30:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_out <= c_next;
        end
    end

endmodule

[hw/rtl/cwc_div_cell.sv]
// One restoring-division step for all divider lanes: one quotient bit per cell.
// Depends on cwc_pkg for the lane types.
module cwc_div_cell (
    input  logic           clk,
    input  logic           en,
    input  cwc_pkg::div_t  c_in,
    output cwc_pkg::div_t  c_out
);

    cwc_pkg::div_t c_next;

    // Shift in one numerator bit per lane and subtract the shared divisor
    always_comb
    begin
        logic [32:0] sh;
        logic [32:0] df;
        logic        ge;
        c_next.d = c_in.d;
        for (int i = 0; i < cwc_pkg::LANES; i++)
        begin
            sh = {c_in.lane[i].r, c_in.lane[i].low[31]};
            df = sh - {1'b0, c_in.d};
            ge = (sh >= {1'b0, c_in.d});
            c_next.lane[i].r   = ge ? df[31:0] : sh[31:0];
            c_next.lane[i].low = {c_in.lane[i].low[30:0], 1'b0};
            c_next.lane[i].q   = {c_in.lane[i].q[30:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_out <= c_next;
        end
    end

endmodule

[hw/rtl/cylinder_wall_collision_response_core.sv]
// Top level of the cylinder wall collision core: config registers, pipeline
// stages, sqrt and divider cell chains. Depends on cwc_pkg and both cells.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one particle per transaction:
//   pos_x/y/z and vel_x/y/z, Q16.16 signed. Output channel (out_valid /
//   out_stall) returns one corrected particle per input, in order, with
//   floor_hit and wall_hit flags.
//   Configuration is written through cfg_we / cfg_index / cfg_data; the user
//   must write it only while no particle is in flight, as the block does not
//   enforce this. The squared radius is latched in the cycle after a radius
//   write. Throughput: one particle per cycle while in_stall is low. The
//   pipeline is the 32-cell square-root and 32-cell divider chains, plus eight
//   arithmetic stages (input, square, compare, normal, dot product, reflection)
//   and the output register. Reset clears all valid bits and loads the
//   register defaults (radius 1.0 and its square, everything else zero).
//   When the receiver stalls, the result holds in the output register and
//   the pipeline keeps moving and accepting until a finished result reaches
//   its last stage; only then is in_stall raised.
module cylinder_wall_collision_response_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] vel_x,
    input  logic [31:0] vel_y,
    input  logic [31:0] vel_z,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] new_pos_x,
    output logic [31:0] new_pos_y,
    output logic [31:0] new_pos_z,
    output logic [31:0] new_vel_x,
    output logic [31:0] new_vel_y,
    output logic [31:0] new_vel_z,
    output logic        floor_hit,
    output logic        wall_hit
);

    // ---------------- configuration registers ----------------
    logic signed [31:0] axis_x_reg, axis_z_reg, floor_y_reg;
    logic [30:0]        radius_reg;
    logic signed [31:0] wvc_x_reg, wvc_y_reg, wvc_z_reg;
    logic [61:0]        rsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg  <= '0;
            axis_z_reg  <= '0;
            floor_y_reg <= '0;
            radius_reg  <= 31'd65536;
            wvc_x_reg   <= '0;
            wvc_y_reg   <= '0;
            wvc_z_reg   <= '0;
            rsq_reg     <= 62'd4294967296;
        end
        else
        begin
            rsq_reg <= 62'(radius_reg) * 62'(radius_reg);
            if (cfg_we)
            begin
                unique case (cwc_pkg::cfg_idx_t'(cfg_index))
                    cwc_pkg::CFG_AXIS_X:  axis_x_reg  <= cfg_data;
                    cwc_pkg::CFG_AXIS_Z:  axis_z_reg  <= cfg_data;
                    cwc_pkg::CFG_FLOOR_Y: floor_y_reg <= cfg_data;
                    cwc_pkg::CFG_RADIUS:  radius_reg  <= cfg_data[30:0];
                    cwc_pkg::CFG_WVC_X:   wvc_x_reg   <= cfg_data;
                    cwc_pkg::CFG_WVC_Y:   wvc_y_reg   <= cfg_data;
                    cwc_pkg::CFG_WVC_Z:   wvc_z_reg   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ---------------- flow control ----------------
    logic out_valid_reg;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic vl_reg [0:cwc_pkg::SQRT_CELLS+cwc_pkg::DIV_CELLS-1];
    logic out_free, adv;

    // The pipeline moves unless a finished result is blocked behind the output
    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        adv      = out_free || !s8_valid_reg;
    end

    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < cwc_pkg::SQRT_CELLS + cwc_pkg::DIV_CELLS; k++)
                vl_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            vl_reg[0]    <= s3_valid_reg;
            for (int k = 1; k < cwc_pkg::SQRT_CELLS + cwc_pkg::DIV_CELLS; k++)
                vl_reg[k] <= vl_reg[k-1];
            s4_valid_reg <= vl_reg[cwc_pkg::SQRT_CELLS+cwc_pkg::DIV_CELLS-1];
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            if (out_free)
                out_valid_reg <= s8_valid_reg;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic signed [31:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic signed [31:0] s1_vx_reg, s1_vy_reg, s1_vz_reg;

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            s1_px_reg <= pos_x;
            s1_py_reg <= pos_y;
            s1_pz_reg <= pos_z;
            s1_vx_reg <= vel_x;
            s1_vy_reg <= vel_y;
            s1_vz_reg <= vel_z;
        end
    end

    // Floor clamp, axis offset, squares and radius-scaled numerators
    logic               s1_fhit;
    logic [31:0]        s1_py_f, s1_vy_f;
    logic signed [32:0] s1_dx, s1_dz;
    logic [32:0]        s1_ndx, s1_ndz;
    logic [31:0]        s1_ax, s1_az;
    logic [63:0]        s1_sqx, s1_sqz, s1_numx, s1_numz;

    always_comb
    begin
        s1_fhit = (s1_py_reg < floor_y_reg);
        s1_py_f = s1_fhit ? floor_y_reg : s1_py_reg;
        s1_vy_f = s1_fhit ? cwc_pkg::sat32(40'(wvc_y_reg) - 40'(s1_vy_reg)) : s1_vy_reg;
        s1_dx   = 33'(axis_x_reg) - 33'(s1_px_reg);
        s1_dz   = 33'(axis_z_reg) - 33'(s1_pz_reg);
        s1_ndx  = -s1_dx;
        s1_ndz  = -s1_dz;
        s1_ax   = s1_dx[32] ? s1_ndx[31:0] : s1_dx[31:0];
        s1_az   = s1_dz[32] ? s1_ndz[31:0] : s1_dz[31:0];
        s1_sqx  = 64'(s1_ax) * 64'(s1_ax);
        s1_sqz  = 64'(s1_az) * 64'(s1_az);
        s1_numx = 64'(s1_ax) * 64'(radius_reg);
        s1_numz = 64'(s1_az) * 64'(radius_reg);
    end

    // ---------------- stage 2 ----------------
    cwc_pkg::pay_t s2_pay_reg;
    logic [63:0]   s2_sqx_reg, s2_sqz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_pay_reg.px   <= s1_px_reg;
            s2_pay_reg.py   <= s1_py_f;
            s2_pay_reg.pz   <= s1_pz_reg;
            s2_pay_reg.vx   <= s1_vx_reg;
            s2_pay_reg.vy   <= s1_vy_f;
            s2_pay_reg.vz   <= s1_vz_reg;
            s2_pay_reg.fhit <= s1_fhit;
            s2_pay_reg.whit <= 1'b0;
            s2_pay_reg.sgnx <= s1_dx[32];
            s2_pay_reg.sgnz <= s1_dz[32];
            s2_pay_reg.ax   <= s1_ax;
            s2_pay_reg.az   <= s1_az;
            s2_pay_reg.numx <= s1_numx;
            s2_pay_reg.numz <= s1_numz;
            s2_sqx_reg      <= s1_sqx;
            s2_sqz_reg      <= s1_sqz;
        end
    end

    // Saturating squared distance and wall test
    logic [64:0]   s2_sum;
    logic [63:0]   s2_lsq;
    cwc_pkg::pay_t s2_pay_w;

    always_comb
    begin
        s2_sum        = {1'b0, s2_sqx_reg} + {1'b0, s2_sqz_reg};
        s2_lsq        = s2_sum[64] ? '1 : s2_sum[63:0];
        s2_pay_w      = s2_pay_reg;
        s2_pay_w.whit = (s2_lsq > 64'(rsq_reg));
    end

    // ---------------- stage 3 ----------------
    cwc_pkg::pay_t s3_pay_reg;
    logic [63:0]   s3_lsq_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_pay_reg <= s2_pay_w;
            s3_lsq_reg <= s2_lsq;
        end
    end

    // ---------------- square-root chain ----------------
    cwc_pkg::sqrt_t sq_d [0:cwc_pkg::SQRT_CELLS];

    always_comb
    begin
        sq_d[0].x    = s3_lsq_reg;
        sq_d[0].rem  = '0;
        sq_d[0].root = '0;
    end

    for (genvar k = 0; k < cwc_pkg::SQRT_CELLS; k++)
    begin : g_sqrt
        cwc_sqrt_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .c_in  (sq_d[k]),
            .c_out (sq_d[k+1])
        );
    end

    // Particle data alongside both chains
    cwc_pkg::pay_t pl_reg [0:cwc_pkg::SQRT_CELLS+cwc_pkg::DIV_CELLS-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pl_reg[0] <= s3_pay_reg;
            for (int k = 1; k < cwc_pkg::SQRT_CELLS + cwc_pkg::DIV_CELLS; k++)
                pl_reg[k] <= pl_reg[k-1];
        end
    end

    // ---------------- divider chain ----------------
    cwc_pkg::div_t dv_d [0:cwc_pkg::DIV_CELLS];
    cwc_pkg::pay_t pm;
    logic [63:0]   nnx, nnz;

    // Divisor is the root; numerators enter as the root leaves the sqrt chain
    always_comb
    begin
        pm  = pl_reg[cwc_pkg::SQRT_CELLS-1];
        nnx = 64'(pm.ax) << cwc_pkg::FRAC_BITS;
        nnz = 64'(pm.az) << cwc_pkg::FRAC_BITS;
        dv_d[0].d = sq_d[cwc_pkg::SQRT_CELLS].root;
        dv_d[0].lane[cwc_pkg::LN_WX] = '{r: pm.numx[63:32], low: pm.numx[31:0], q: '0};
        dv_d[0].lane[cwc_pkg::LN_WZ] = '{r: pm.numz[63:32], low: pm.numz[31:0], q: '0};
        dv_d[0].lane[cwc_pkg::LN_NX] = '{r: nnx[63:32], low: nnx[31:0], q: '0};
        dv_d[0].lane[cwc_pkg::LN_NZ] = '{r: nnz[63:32], low: nnz[31:0], q: '0};
    end

    for (genvar k = 0; k < cwc_pkg::DIV_CELLS; k++)
    begin : g_div
        cwc_div_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .c_in  (dv_d[k]),
            .c_out (dv_d[k+1])
        );
    end

    // Wall position and unit normal from the quotients
    cwc_pkg::pay_t              pe;
    logic signed [33:0]         wp_x, wp_z;
    logic [cwc_pkg::NW-1:0]     nmag_x, nmag_z, nneg_x, nneg_z;

    always_comb
    begin
        pe = pl_reg[cwc_pkg::SQRT_CELLS+cwc_pkg::DIV_CELLS-1];
        wp_x = pe.sgnx
            ? 34'(axis_x_reg) + 34'(dv_d[cwc_pkg::DIV_CELLS].lane[cwc_pkg::LN_WX].q)
            : 34'(axis_x_reg) - 34'(dv_d[cwc_pkg::DIV_CELLS].lane[cwc_pkg::LN_WX].q);
        wp_z = pe.sgnz
            ? 34'(axis_z_reg) + 34'(dv_d[cwc_pkg::DIV_CELLS].lane[cwc_pkg::LN_WZ].q)
            : 34'(axis_z_reg) - 34'(dv_d[cwc_pkg::DIV_CELLS].lane[cwc_pkg::LN_WZ].q);
        nmag_x = {1'b0, dv_d[cwc_pkg::DIV_CELLS].lane[cwc_pkg::LN_NX].q[cwc_pkg::FRAC_BITS:0]};
        nmag_z = {1'b0, dv_d[cwc_pkg::DIV_CELLS].lane[cwc_pkg::LN_NZ].q[cwc_pkg::FRAC_BITS:0]};
        nneg_x = -nmag_x;
        nneg_z = -nmag_z;
    end

    // ---------------- stage 4 ----------------
    logic [31:0]                s4_px_reg, s4_py_reg, s4_pz_reg;
    logic signed [31:0]         s4_vx_reg, s4_vy_reg, s4_vz_reg;
    logic                       s4_fhit_reg, s4_whit_reg;
    logic signed [cwc_pkg::NW-1:0] s4_nx_reg, s4_nz_reg, s4_mx_reg, s4_mz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_px_reg   <= pe.whit ? cwc_pkg::sat32(40'(wp_x)) : pe.px;
            s4_py_reg   <= pe.py;
            s4_pz_reg   <= pe.whit ? cwc_pkg::sat32(40'(wp_z)) : pe.pz;
            s4_vx_reg   <= pe.vx;
            s4_vy_reg   <= pe.vy;
            s4_vz_reg   <= pe.vz;
            s4_fhit_reg <= pe.fhit;
            s4_whit_reg <= pe.whit;
            s4_nx_reg   <= pe.sgnx ? nneg_x : nmag_x;
            s4_nz_reg   <= pe.sgnz ? nneg_z : nmag_z;
            s4_mx_reg   <= nmag_x;
            s4_mz_reg   <= nmag_z;
        end
    end

    // ---------------- stage 5: dot-product and container-term products ----
    logic [31:0]                    s5_px_reg, s5_py_reg, s5_pz_reg;
    logic signed [31:0]             s5_vx_reg, s5_vy_reg, s5_vz_reg;
    logic                           s5_fhit_reg, s5_whit_reg;
    logic signed [cwc_pkg::NW-1:0]  s5_nx_reg, s5_nz_reg;
    logic signed [cwc_pkg::NW+31:0] s5_m1_reg, s5_m2_reg, s5_cx_reg, s5_cz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_px_reg   <= s4_px_reg;
            s5_py_reg   <= s4_py_reg;
            s5_pz_reg   <= s4_pz_reg;
            s5_vx_reg   <= s4_vx_reg;
            s5_vy_reg   <= s4_vy_reg;
            s5_vz_reg   <= s4_vz_reg;
            s5_fhit_reg <= s4_fhit_reg;
            s5_whit_reg <= s4_whit_reg;
            s5_nx_reg   <= s4_nx_reg;
            s5_nz_reg   <= s4_nz_reg;
            s5_m1_reg   <= s4_nx_reg * s4_vx_reg;
            s5_m2_reg   <= s4_nz_reg * s4_vz_reg;
            s5_cx_reg   <= wvc_x_reg * s4_mx_reg;
            s5_cz_reg   <= wvc_z_reg * s4_mz_reg;
        end
    end

    // Dot product and container terms, floored
    logic signed [cwc_pkg::NW+32:0] s5_sum, s5_dsh;
    logic signed [cwc_pkg::NW+31:0] s5_csx, s5_csz;

    always_comb
    begin
        s5_sum = (cwc_pkg::NW+33)'(s5_m1_reg) + (cwc_pkg::NW+33)'(s5_m2_reg);
        s5_dsh = s5_sum >>> cwc_pkg::FRAC_BITS;
        s5_csx = s5_cx_reg >>> cwc_pkg::FRAC_BITS;
        s5_csz = s5_cz_reg >>> cwc_pkg::FRAC_BITS;
    end

    // ---------------- stage 6 ----------------
    logic [31:0]                   s6_px_reg, s6_py_reg, s6_pz_reg;
    logic signed [31:0]            s6_vx_reg, s6_vy_reg, s6_vz_reg;
    logic                          s6_fhit_reg, s6_whit_reg;
    logic signed [cwc_pkg::NW-1:0] s6_nx_reg, s6_nz_reg;
    logic signed [33:0]            s6_dot_reg, s6_t2x_reg, s6_t2z_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_px_reg   <= s5_px_reg;
            s6_py_reg   <= s5_py_reg;
            s6_pz_reg   <= s5_pz_reg;
            s6_vx_reg   <= s5_vx_reg;
            s6_vy_reg   <= s5_vy_reg;
            s6_vz_reg   <= s5_vz_reg;
            s6_fhit_reg <= s5_fhit_reg;
            s6_whit_reg <= s5_whit_reg;
            s6_nx_reg   <= s5_nx_reg;
            s6_nz_reg   <= s5_nz_reg;
            s6_dot_reg  <= s5_dsh[33:0];
            s6_t2x_reg  <= s5_csx[33:0];
            s6_t2z_reg  <= s5_csz[33:0];
        end
    end

    // ---------------- stage 7: reflection products ----------------
    logic signed [34:0]             s6_dot2;
    logic [31:0]                    s7_px_reg, s7_py_reg, s7_pz_reg;
    logic signed [31:0]             s7_vx_reg, s7_vy_reg, s7_vz_reg;
    logic                           s7_fhit_reg, s7_whit_reg;
    logic signed [33:0]             s7_t2x_reg, s7_t2z_reg;
    logic signed [cwc_pkg::NW+34:0] s7_p1_reg, s7_p2_reg;

    assign s6_dot2 = {s6_dot_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_px_reg   <= s6_px_reg;
            s7_py_reg   <= s6_py_reg;
            s7_pz_reg   <= s6_pz_reg;
            s7_vx_reg   <= s6_vx_reg;
            s7_vy_reg   <= s6_vy_reg;
            s7_vz_reg   <= s6_vz_reg;
            s7_fhit_reg <= s6_fhit_reg;
            s7_whit_reg <= s6_whit_reg;
            s7_t2x_reg  <= s6_t2x_reg;
            s7_t2z_reg  <= s6_t2z_reg;
            s7_p1_reg   <= s6_dot2 * s6_nx_reg;
            s7_p2_reg   <= s6_dot2 * s6_nz_reg;
        end
    end

    // Reflected velocity plus container term
    logic signed [cwc_pkg::NW+34:0] s7_t1x, s7_t1z;
    logic signed [39:0]             s7_sx, s7_sz;

    always_comb
    begin
        s7_t1x = s7_p1_reg >>> cwc_pkg::FRAC_BITS;
        s7_t1z = s7_p2_reg >>> cwc_pkg::FRAC_BITS;
        s7_sx  = 40'(s7_vx_reg) - 40'(s7_t1x) + 40'(s7_t2x_reg);
        s7_sz  = 40'(s7_vz_reg) - 40'(s7_t1z) + 40'(s7_t2z_reg);
    end

    // ---------------- stage 8 ----------------
    logic [31:0] s8_px_reg, s8_py_reg, s8_pz_reg, s8_vx_reg, s8_vy_reg, s8_vz_reg;
    logic        s8_fhit_reg, s8_whit_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_px_reg   <= s7_px_reg;
            s8_py_reg   <= s7_py_reg;
            s8_pz_reg   <= s7_pz_reg;
            s8_vx_reg   <= s7_whit_reg ? cwc_pkg::sat32(s7_sx) : s7_vx_reg;
            s8_vy_reg   <= s7_vy_reg;
            s8_vz_reg   <= s7_whit_reg ? cwc_pkg::sat32(s7_sz) : s7_vz_reg;
            s8_fhit_reg <= s7_fhit_reg;
            s8_whit_reg <= s7_whit_reg;
        end
    end

    // ---------------- output register ----------------
    logic [31:0] o_px_reg, o_py_reg, o_pz_reg, o_vx_reg, o_vy_reg, o_vz_reg;
    logic        o_fhit_reg, o_whit_reg;

    always_ff @(posedge clk)
    begin
        if (out_free && s8_valid_reg)
        begin
            o_px_reg   <= s8_px_reg;
            o_py_reg   <= s8_py_reg;
            o_pz_reg   <= s8_pz_reg;
            o_vx_reg   <= s8_vx_reg;
            o_vy_reg   <= s8_vy_reg;
            o_vz_reg   <= s8_vz_reg;
            o_fhit_reg <= s8_fhit_reg;
            o_whit_reg <= s8_whit_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_pos_x = o_px_reg;
    assign new_pos_y = o_py_reg;
    assign new_pos_z = o_pz_reg;
    assign new_vel_x = o_vx_reg;
    assign new_vel_y = o_vy_reg;
    assign new_vel_z = o_vz_reg;
    assign floor_hit = o_fhit_reg;
    assign wall_hit  = o_whit_reg;

endmodule

[hw/rtl/cwc_checker.sv]
// Port-level checks for the cylinder wall collision core, bound to the top.
// Depends only on the top level's ports.
module cwc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] new_pos_x,
    input logic [31:0] new_vel_x
);

    // Transactions accepted but not yet delivered
    logic [7:0] cnt_reg;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (in_acc && !out_acc)
            cnt_reg <= cnt_reg + 8'd1;
        else if (!in_acc && out_acc)
            cnt_reg <= cnt_reg - 8'd1;
    end

    // No result without an outstanding transaction
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cnt_reg != 8'd0))
        else $error("result without an outstanding transaction");

    // Input stalls only while a result is blocked at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with output free");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(new_pos_x) && $stable(new_vel_x)))
        else $error("stalled result changed");

endmodule

bind cylinder_wall_collision_response_core cwc_checker u_cwc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .new_pos_x (new_pos_x),
    .new_vel_x (new_vel_x)
);
